[rtl/core/assert_macros.svh]
// assertion macros for the checker file spd_chk.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, ignored while reset is held
`define SPD_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked property that also holds across reset
`define SPD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/spd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package spd_pkg;

    // sizing
    localparam int MAX_SLOTS_DEF = 1024;
    localparam int PAGE_BYTES    = 16384;
    localparam int SLOT_BYTES    = 8;

    // field widths
    localparam int MODE_W     = 3;
    localparam int ID_W       = 31;
    localparam int BYTES_W    = 15;
    localparam int OFF_W      = 14;
    localparam int STATUS_W   = 3;
    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 64;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 31;

    // register reset values
    localparam int USABLE_RST_VAL = 16320;
    localparam logic [ID_W-1:0]    FIRST_ROW_ID_RST = '0;
    localparam logic [BYTES_W-1:0] USABLE_RST       = BYTES_W'(USABLE_RST_VAL);
    localparam logic [BYTES_W-1:0] FREE_RST =
        BYTES_W'((USABLE_RST_VAL < PAGE_BYTES) ? USABLE_RST_VAL : PAGE_BYTES);

    typedef enum logic [MODE_W-1:0] {
        MODE_FORMAT = 3'd0,
        MODE_INSERT = 3'd1,
        MODE_DELETE = 3'd2,
        MODE_LOOKUP = 3'd3,
        MODE_EXISTS = 3'd4,
        MODE_SCAN   = 3'd5,
        MODE_REWIND = 3'd6
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK        = 3'd0,
        STS_NO_SPACE  = 3'd1,
        STS_NOT_FOUND = 3'd2,
        STS_DELETED   = 3'd3,
        STS_NO_MORE   = 3'd4
    } status_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_FIRST_ROW_ID = 1'b0,
        CFG_USABLE_BYTES = 1'b1
    } cfg_reg_t;

    // one directory entry
    typedef struct packed {
        logic              tomb;
        logic [ID_W-1:0]   row_id;
        logic [OFF_W-1:0]  offset;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_WALK = 2'd1,
        ST_DONE = 2'd2
    } ctrl_state_t;

    typedef struct packed {
        logic accept;
        logic walk;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic walk_done;
        logic out_busy;
    } ctrl_sts_t;

endpackage

`default_nettype wire

[rtl/core/spd_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module spd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[rtl/core/spd_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module spd_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    output spd_pkg::ctrl_cmd_t       cmd,
    input  wire spd_pkg::ctrl_sts_t  sts
);

    spd_pkg::ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= spd_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            spd_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = spd_pkg::ST_WALK;
                end
            end
            spd_pkg::ST_WALK: begin
                if (sts.walk_done) begin
                    state_next = spd_pkg::ST_DONE;
                end
            end
            spd_pkg::ST_DONE: begin
                if (!sts.out_busy) begin
                    state_next = spd_pkg::ST_IDLE;
                end
            end
            default: state_next = spd_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            spd_pkg::ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            spd_pkg::ST_WALK: begin
                cmd.walk = 1'b1;
            end
            spd_pkg::ST_DONE: begin
                cmd.finish = !sts.out_busy;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/core/spd_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none

module spd_datapath #(
    parameter int MAX_SLOTS = spd_pkg::MAX_SLOTS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire spd_pkg::ctrl_cmd_t              cmd,
    output spd_pkg::ctrl_sts_t                   sts,
    input  wire logic [spd_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire logic                            cfg_wr_en,
    input  wire logic [spd_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [spd_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [spd_pkg::M_TDATA_W-1:0]   m_tdata
);

    localparam int AW = $clog2(MAX_SLOTS);
    localparam int CW = $clog2(MAX_SLOTS + 1);
    localparam int IW = spd_pkg::ID_W;
    localparam int BW = spd_pkg::BYTES_W;
    localparam int OW = spd_pkg::OFF_W;
    localparam int NW = BW + 1;
    localparam int MW = spd_pkg::MODE_W;

    // configuration registers
    logic [IW-1:0] first_id_reg;
    logic [BW-1:0] usable_reg;

    // page state
    logic [CW-1:0] row_count_reg, row_count_next;
    logic [IW-1:0] next_id_reg, next_id_next;
    logic [BW-1:0] free_reg, free_next;
    logic [BW-1:0] used_reg, used_next;
    logic [CW-1:0] scan_idx_reg, scan_idx_next;
    logic          dirty_reg, dirty_next;

    // current request
    spd_pkg::mode_t mode_reg, mode_next;
    logic [IW-1:0]  id_reg, id_next;
    logic [BW-1:0]  rec_reg, rec_next;

    // directory walk
    logic [CW-1:0]  left_reg, left_next;
    logic           rd_vld_reg, rd_vld_next;
    logic [AW-1:0]  rd_addr_reg, rd_addr_next;
    logic           found_reg, found_next;
    logic [AW-1:0]  found_addr_reg, found_addr_next;
    spd_pkg::slot_t found_slot_reg, found_slot_next;

    // result register
    logic              out_valid_reg, out_valid_next;
    spd_pkg::status_t  out_status_reg, out_status_next;
    logic [IW-1:0]     out_rid_reg, out_rid_next;
    logic [OW-1:0]     out_off_reg, out_off_next;
    logic [BW-1:0]     out_free_reg, out_free_next;
    logic              out_dirty_reg, out_dirty_next;

    // directory memory
    logic                       ram_wr_en, ram_rd_en;
    logic [AW-1:0]              ram_wr_addr, ram_rd_addr;
    logic [spd_pkg::SLOT_W-1:0] ram_wr_data, ram_rd_data;
    spd_pkg::slot_t             rd_slot, wr_slot;

    spd_pkg::mode_t in_mode;
    logic [IW-1:0]  in_id;
    logic [BW-1:0]  in_rec;
    logic           in_range;
    logic [BW-1:0]  fmt_free;
    logic [NW-1:0]  need;
    logic           no_room;
    logic           id_match, cond, hit, issue;

    assign in_mode = spd_pkg::mode_t'(s_tdata[MW-1:0]);
    assign in_id   = s_tdata[MW+IW-1:MW];
    assign in_rec  = s_tdata[MW+IW+BW-1:MW+IW];
    assign in_range = (in_id >= first_id_reg) && (in_id < next_id_reg);

    assign fmt_free = (32'(usable_reg) > 32'(spd_pkg::PAGE_BYTES)) ?
                      BW'(spd_pkg::PAGE_BYTES) : usable_reg;
    assign need     = {1'b0, rec_reg} + NW'(spd_pkg::SLOT_BYTES);
    assign no_room  = (row_count_reg >= CW'(MAX_SLOTS)) || ({1'b0, free_reg} < need);

    assign rd_slot  = spd_pkg::slot_t'(ram_rd_data);
    assign id_match = (rd_slot.row_id == id_reg);

    always_comb begin
        case (mode_reg)
            spd_pkg::MODE_DELETE,
            spd_pkg::MODE_LOOKUP: cond = id_match && !rd_slot.tomb;
            spd_pkg::MODE_EXISTS: cond = id_match;
            spd_pkg::MODE_SCAN:   cond = !rd_slot.tomb;
            default:              cond = 1'b0;
        endcase
    end

    assign hit   = rd_vld_reg && cond;
    assign issue = cmd.walk && !hit && (left_reg != '0);

    assign ram_rd_en   = issue;
    assign ram_rd_addr = AW'(left_reg - CW'(1));
    assign ram_wr_data = spd_pkg::SLOT_W'(wr_slot);

    assign sts.walk_done = hit || (left_reg == '0);
    assign sts.out_busy  = out_valid_reg && !m_tready;

    always_comb begin
        row_count_next  = row_count_reg;
        next_id_next    = next_id_reg;
        free_next       = free_reg;
        used_next       = used_reg;
        scan_idx_next   = scan_idx_reg;
        dirty_next      = dirty_reg;
        mode_next       = mode_reg;
        id_next         = id_reg;
        rec_next        = rec_reg;
        left_next       = left_reg;
        rd_vld_next     = rd_vld_reg;
        rd_addr_next    = rd_addr_reg;
        found_next      = found_reg;
        found_addr_next = found_addr_reg;
        found_slot_next = found_slot_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_rid_next    = out_rid_reg;
        out_off_next    = out_off_reg;
        out_free_next   = out_free_reg;
        out_dirty_next  = out_dirty_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = row_count_reg[AW-1:0];
        wr_slot         = '0;

        if (cmd.accept) begin
            mode_next   = in_mode;
            id_next     = in_id;
            rec_next    = in_rec;
            found_next  = 1'b0;
            rd_vld_next = 1'b0;
            case (in_mode)
                spd_pkg::MODE_DELETE,
                spd_pkg::MODE_LOOKUP: left_next = row_count_reg;
                spd_pkg::MODE_EXISTS: left_next = in_range ? row_count_reg : '0;
                spd_pkg::MODE_SCAN:   left_next = row_count_reg - scan_idx_reg;
                default:              left_next = '0;
            endcase
        end

        if (cmd.walk) begin
            rd_vld_next = issue;
            if (issue) begin
                left_next    = left_reg - CW'(1);
                rd_addr_next = ram_rd_addr;
            end
            if (hit) begin
                found_next      = 1'b1;
                found_addr_next = rd_addr_reg;
                found_slot_next = rd_slot;
            end
        end

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        if (cmd.finish) begin
            out_valid_next  = 1'b1;
            out_status_next = spd_pkg::STS_OK;
            out_rid_next    = '0;
            out_off_next    = '0;
            case (mode_reg)
                spd_pkg::MODE_FORMAT: begin
                    row_count_next = '0;
                    next_id_next   = first_id_reg;
                    free_next      = fmt_free;
                    used_next      = '0;
                    scan_idx_next  = '0;
                    dirty_next     = 1'b0;
                end
                spd_pkg::MODE_INSERT: begin
                    if (no_room) begin
                        out_status_next = spd_pkg::STS_NO_SPACE;
                    end else begin
                        ram_wr_en      = 1'b1;
                        wr_slot.tomb   = 1'b0;
                        wr_slot.row_id = next_id_reg;
                        wr_slot.offset = used_reg[OW-1:0];
                        out_rid_next   = next_id_reg;
                        out_off_next   = used_reg[OW-1:0];
                        row_count_next = row_count_reg + CW'(1);
                        next_id_next   = next_id_reg + IW'(1);
                        used_next      = used_reg + rec_reg;
                        free_next      = BW'({1'b0, free_reg} - need);
                        dirty_next     = 1'b1;
                    end
                end
                spd_pkg::MODE_DELETE: begin
                    if (found_reg) begin
                        ram_wr_en    = 1'b1;
                        ram_wr_addr  = found_addr_reg;
                        wr_slot      = found_slot_reg;
                        wr_slot.tomb = 1'b1;
                        out_rid_next = id_reg;
                        out_off_next = found_slot_reg.offset;
                        dirty_next   = 1'b1;
                    end else begin
                        out_status_next = spd_pkg::STS_NOT_FOUND;
                    end
                end
                spd_pkg::MODE_LOOKUP: begin
                    if (found_reg) begin
                        out_rid_next = id_reg;
                        out_off_next = found_slot_reg.offset;
                    end else begin
                        out_status_next = spd_pkg::STS_NOT_FOUND;
                    end
                end
                spd_pkg::MODE_EXISTS: begin
                    if (found_reg) begin
                        out_rid_next = id_reg;
                        out_off_next = found_slot_reg.offset;
                        if (found_slot_reg.tomb) begin
                            out_status_next = spd_pkg::STS_DELETED;
                        end
                    end else begin
                        out_status_next = spd_pkg::STS_NOT_FOUND;
                    end
                end
                spd_pkg::MODE_SCAN: begin
                    if (found_reg) begin
                        out_rid_next  = found_slot_reg.row_id;
                        out_off_next  = found_slot_reg.offset;
                        scan_idx_next = row_count_reg - CW'(found_addr_reg);
                    end else begin
                        out_status_next = spd_pkg::STS_NO_MORE;
                        scan_idx_next   = row_count_reg;
                    end
                end
                spd_pkg::MODE_REWIND: begin
                    scan_idx_next = '0;
                end
                default: begin
                    out_status_next = spd_pkg::STS_OK;
                end
            endcase
            out_free_next  = free_next;
            out_dirty_next = dirty_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_id_reg <= spd_pkg::FIRST_ROW_ID_RST;
            usable_reg   <= spd_pkg::USABLE_RST;
        end else if (cfg_wr_en) begin
            case (spd_pkg::cfg_reg_t'(cfg_addr))
                spd_pkg::CFG_FIRST_ROW_ID: first_id_reg <= cfg_wr_data[IW-1:0];
                spd_pkg::CFG_USABLE_BYTES: usable_reg   <= cfg_wr_data[BW-1:0];
                default:                   usable_reg   <= usable_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg <= '0;
            next_id_reg   <= spd_pkg::FIRST_ROW_ID_RST;
            free_reg      <= spd_pkg::FREE_RST;
            used_reg      <= '0;
            scan_idx_reg  <= '0;
            dirty_reg     <= 1'b0;
            left_reg      <= '0;
            rd_vld_reg    <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            row_count_reg <= row_count_next;
            next_id_reg   <= next_id_next;
            free_reg      <= free_next;
            used_reg      <= used_next;
            scan_idx_reg  <= scan_idx_next;
            dirty_reg     <= dirty_next;
            left_reg      <= left_next;
            rd_vld_reg    <= rd_vld_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg       <= mode_next;
        id_reg         <= id_next;
        rec_reg        <= rec_next;
        rd_addr_reg    <= rd_addr_next;
        found_addr_reg <= found_addr_next;
        found_slot_reg <= found_slot_next;
        out_status_reg <= out_status_next;
        out_rid_reg    <= out_rid_next;
        out_off_reg    <= out_off_next;
        out_free_reg   <= out_free_next;
        out_dirty_reg  <= out_dirty_next;
    end

    spd_ram #(
        .WIDTH (spd_pkg::SLOT_W),
        .DEPTH (MAX_SLOTS)
    ) u_dir_ram (
        .clk     (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_dirty_reg, out_free_reg, out_off_reg, out_rid_reg,
                       spd_pkg::STATUS_W'(out_status_reg)};

endmodule

`default_nettype wire

[rtl/core/slotted_page_row_directory.sv]
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  handshake            payload
// s_        in   s_tvalid / s_tready  s_tdata: mode, row_id, record_bytes
// m_        out  m_tvalid / m_tready  m_tdata: status, result_row_id, record_offset,
//                                     free_left, page_dirty
// cfg_      in   cfg_wr_en            cfg_addr selects first_row_id or usable_bytes
//
// format, insert, rewind and unused modes skip the directory walk and post their result
// through the walk and done states; s_tready rises again as the result is posted
// lookup, delete, scan and in-range exists read the directory newest slot first, stopping at
// the first hit or the oldest slot, through the single read port of the directory ram
// one request is in flight at a time; reset is synchronous, active low, leaves an empty page
// a stalled m_tready holds the result and delays completion of the next request

module slotted_page_row_directory #(
    parameter int MAX_SLOTS = spd_pkg::MAX_SLOTS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // mode [2:0], row_id [33:3], record_bytes [48:34], zero pad [55:49]
    input  wire logic [spd_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // status [2:0], result_row_id [33:3], record_offset [47:34],
    // free_left [62:48], page_dirty [63]
    output logic      [spd_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic                            cfg_wr_en,
    input  wire logic [spd_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [spd_pkg::CFG_DATA_W-1:0]  cfg_wr_data
);

    // command and status between sequencer and datapath
    spd_pkg::ctrl_cmd_t cmd;
    spd_pkg::ctrl_sts_t sts;

    // sequencer: accept, walk the directory, then post the result
    spd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // page state, directory ram, newest-first walk and output register
    spd_datapath #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .s_tdata     (s_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

`default_nettype wire

[rtl/core/spd_chk.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module spd_chk (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic [spd_pkg::M_TDATA_W-1:0]  m_tdata,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready
);

    logic miss;

    assign miss = (m_tdata[2:0] == spd_pkg::STS_NOT_FOUND) ||
                  (m_tdata[2:0] == spd_pkg::STS_NO_MORE);

    // result holds while stalled
    `SPD_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result dropped or changed while stalled")

    // one request in flight
    `SPD_ASSERT(a_one_req, aclk, aresetn, s_tvalid && s_tready |=> !s_tready, "second request taken while busy")

    // no result appears the cycle after a request
    `SPD_ASSERT(a_no_early, aclk, aresetn, s_tvalid && s_tready |=> !$rose(m_tvalid), "result posted too early")

    // a miss carries no row id and no offset
    `SPD_ASSERT(a_miss_zero, aclk, aresetn, m_tvalid && miss |-> m_tdata[47:3] == '0, "miss with nonzero row id or offset")

    // reset clears the output
    `SPD_ASSERT_ALWAYS(a_rst_out, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

bind slotted_page_row_directory spd_chk u_spd_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

`default_nettype wire

[verif/tb_top.sv]
`timescale 1ns / 1ps

// page directory regression: directed pokes at each mode and corner, register extremes,
// four pacing phases of random page traffic and one long output hold-off; every
// result is checked field by field against a page model kept inside this bench

module tb_top;

    localparam int DIR_SLOTS  = spd_pkg::MAX_SLOTS_DEF;
    localparam int MODE_W     = spd_pkg::MODE_W;
    localparam int ID_W       = spd_pkg::ID_W;
    localparam int BYTES_W    = spd_pkg::BYTES_W;
    localparam int OFF_W      = spd_pkg::OFF_W;
    localparam int S_TDATA_W  = spd_pkg::S_TDATA_W;
    localparam int M_TDATA_W  = spd_pkg::M_TDATA_W;
    localparam int CFG_ADDR_W = spd_pkg::CFG_ADDR_W;
    localparam int CFG_DATA_W = spd_pkg::CFG_DATA_W;
    localparam int PAGE_BYTES = spd_pkg::PAGE_BYTES;
    localparam int SLOT_BYTES = spd_pkg::SLOT_BYTES;
    // the only mode code with no meaning: must leave the page untouched
    localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;
    localparam logic [ID_W-1:0]   ID_MAX      = '1;
    localparam logic [BYTES_W-1:0] BYTES_MAX  = '1;
    localparam realtime RUN_LIMIT = 120ms;

    typedef struct {
        logic [MODE_W-1:0]  mode;
        logic [ID_W-1:0]    row_id;
        logic [BYTES_W-1:0] rec_bytes;
    } page_req_t;

    typedef struct {
        spd_pkg::status_t   status;
        logic [ID_W-1:0]    row_id;
        logic [OFF_W-1:0]   offset;
        logic [BYTES_W-1:0] free_left;
        logic               dirty;
    } page_resp_t;

    logic                    aclk;
    logic                    aresetn;
    logic [S_TDATA_W-1:0]    s_tdata;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [M_TDATA_W-1:0]    m_tdata;
    logic                    m_tvalid;
    logic                    m_tready;
    logic                    cfg_wr_en;
    logic [CFG_ADDR_W-1:0]   cfg_addr;
    logic [CFG_DATA_W-1:0]   cfg_wr_data;

    slotted_page_row_directory #(
        .MAX_SLOTS (DIR_SLOTS)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata     (s_tdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .m_tdata     (m_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    // pacing knobs, set by the test sequence; the result pacer clears recv_hold_cycles
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned recv_hold_cycles;

    // page model: registers, directory and page counters
    logic [ID_W-1:0]    pg_first_reg;
    logic [BYTES_W-1:0] pg_usable_reg;
    spd_pkg::slot_t     pg_dir [DIR_SLOTS];
    int                 pg_rows;
    int                 pg_scan;
    logic [ID_W-1:0]    pg_next_id;
    logic [BYTES_W-1:0] pg_free;
    logic [BYTES_W-1:0] pg_used;
    logic               pg_dirty;

    page_resp_t page_results_due [$];

    int unsigned requests_sent;
    int unsigned results_matched;
    int unsigned result_errors;
    int          deepest_rows;

    // ------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // hard stop in case the block hangs
    initial begin
        #(RUN_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // page model
    // ------------------------------------------------------------------
    // registers take effect here, not at the write; exists alone reads the first id live
    function automatic void format_page_model();
        logic [BYTES_W-1:0] cap;
        cap = (pg_usable_reg > PAGE_BYTES) ? BYTES_W'(PAGE_BYTES) : pg_usable_reg;
        pg_rows    = 0;
        pg_scan    = 0;
        pg_next_id = pg_first_reg;
        pg_free    = cap;
        pg_used    = '0;
        pg_dirty   = 1'b0;
    endfunction

    // newest-first search, -1 when no slot matches
    function automatic int newest_slot(logic [ID_W-1:0] id, bit live_only);
        for (int k = pg_rows - 1; k >= 0; k--) begin
            if (pg_dir[k].row_id == id && (!live_only || !pg_dir[k].tomb))
                return k;
        end
        return -1;
    endfunction

    function automatic page_resp_t apply_page_request(page_req_t req);
        page_resp_t r;
        int         need;
        int         s;
        r.status = spd_pkg::STS_OK;
        r.row_id = '0;
        r.offset = '0;
        case (req.mode)
            spd_pkg::MODE_FORMAT: format_page_model();
            spd_pkg::MODE_INSERT: begin
                need = int'(req.rec_bytes) + SLOT_BYTES;
                if (pg_rows >= DIR_SLOTS || int'(pg_free) < need) begin
                    r.status = spd_pkg::STS_NO_SPACE;
                end else begin
                    r.row_id = pg_next_id;
                    r.offset = pg_used[OFF_W-1:0];
                    pg_dir[pg_rows] = '{tomb: 1'b0, row_id: pg_next_id,
                                        offset: pg_used[OFF_W-1:0]};
                    pg_rows++;
                    pg_next_id = pg_next_id + 1'b1;
                    pg_used    = pg_used + req.rec_bytes;
                    pg_free    = pg_free - BYTES_W'(need);
                    pg_dirty   = 1'b1;
                    if (pg_rows > deepest_rows)
                        deepest_rows = pg_rows;
                end
            end
            spd_pkg::MODE_DELETE, spd_pkg::MODE_LOOKUP: begin
                s = newest_slot(req.row_id, 1'b1);
                if (s < 0) begin
                    r.status = spd_pkg::STS_NOT_FOUND;
                end else begin
                    r.row_id = req.row_id;
                    r.offset = pg_dir[s].offset;
                    if (req.mode == spd_pkg::MODE_DELETE) begin
                        pg_dir[s].tomb = 1'b1;
                        pg_dirty = 1'b1;
                    end
                end
            end
            spd_pkg::MODE_EXISTS: begin
                // range check against the live register, not the value at format
                if (req.row_id < pg_first_reg || req.row_id >= pg_next_id) begin
                    r.status = spd_pkg::STS_NOT_FOUND;
                end else begin
                    s = newest_slot(req.row_id, 1'b0);
                    if (s < 0) begin
                        r.status = spd_pkg::STS_NOT_FOUND;
                    end else begin
                        r.row_id = req.row_id;
                        r.offset = pg_dir[s].offset;
                        if (pg_dir[s].tomb)
                            r.status = spd_pkg::STS_DELETED;
                    end
                end
            end
            spd_pkg::MODE_SCAN: begin
                while (pg_scan < pg_rows && pg_dir[pg_rows - 1 - pg_scan].tomb)
                    pg_scan++;
                if (pg_scan >= pg_rows) begin
                    r.status = spd_pkg::STS_NO_MORE;
                end else begin
                    s = pg_rows - 1 - pg_scan;
                    r.row_id = pg_dir[s].row_id;
                    r.offset = pg_dir[s].offset;
                    pg_scan++;
                end
            end
            spd_pkg::MODE_REWIND: pg_scan = 0;
            default: ;
        endcase
        r.free_left = pg_free;
        r.dirty     = pg_dirty;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------
    // tvalid stays up between back-to-back requests; it drops for idle cycles and in drain_page
    task automatic send_page_request(input page_req_t req);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tdata  <= {{(S_TDATA_W - MODE_W - ID_W - BYTES_W){1'b0}},
                     req.rec_bytes, req.row_id, req.mode};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        page_results_due.push_back(apply_page_request(req));
        requests_sent++;
    endtask

    task automatic send_op(input logic [MODE_W-1:0] mode, input logic [ID_W-1:0] id,
                           input logic [BYTES_W-1:0] rec);
        page_req_t req;
        req.mode      = mode;
        req.row_id    = id;
        req.rec_bytes = rec;
        send_page_request(req);
    endtask

    // every request yields a result, so an empty queue means the block is idle
    task automatic drain_page();
        s_tvalid <= 1'b0;
        while (page_results_due.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_page_register(input spd_pkg::cfg_reg_t idx,
                                       input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        @(posedge aclk);
        if (idx == spd_pkg::CFG_FIRST_ROW_ID)
            pg_first_reg = val[ID_W-1:0];
        else
            pg_usable_reg = val[BYTES_W-1:0];
    endtask

    // ------------------------------------------------------------------
    // result side: random stalls plus an optional long hold-off
    // ------------------------------------------------------------------
    initial begin : result_pacer
        int unsigned hold_left;
        hold_left = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (recv_hold_cycles != 0) begin
                hold_left = recv_hold_cycles;
                recv_hold_cycles = 0;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic report_field(input string name, input longint unsigned want,
                                input longint unsigned got);
        if (want != got) begin
            $display("%0t: mismatch in %s: expected %0d, got %0d", $time, name, want, got);
            result_errors++;
        end
    endtask

    // compare every accepted result with the oldest expectation
    always @(posedge aclk) begin : result_check
        page_resp_t want;
        page_resp_t got;
        int unsigned errs_before;
        if (aresetn && m_tvalid && m_tready) begin
            got.status    = spd_pkg::status_t'(m_tdata[2:0]);
            got.row_id    = m_tdata[33:3];
            got.offset    = m_tdata[47:34];
            got.free_left = m_tdata[62:48];
            got.dirty     = m_tdata[63];
            if (page_results_due.size() == 0) begin
                $display("%0t: unexpected result, expected none, got status %0d row %0d",
                         $time, got.status, got.row_id);
                result_errors++;
            end else begin
                want = page_results_due.pop_front();
                errs_before = result_errors;
                report_field("status", want.status, got.status);
                report_field("result_row_id", want.row_id, got.row_id);
                report_field("record_offset", want.offset, got.offset);
                report_field("free_left", want.free_left, got.free_left);
                report_field("page_dirty", want.dirty, got.dirty);
                if (result_errors == errs_before)
                    results_matched++;
            end
        end
    end

    // ------------------------------------------------------------------
    // random request generation
    // ------------------------------------------------------------------
    // mostly ids the page has handed out, sometimes absent or out-of-range ones
    function automatic logic [ID_W-1:0] pick_row_id();
        case ($urandom_range(9))
            0: return ID_W'($urandom);
            1: return pg_next_id;
            2: return pg_first_reg - 1'b1;
            default: begin
                if (pg_rows == 0)
                    return pg_first_reg + ID_W'($urandom_range(3));
                return pg_dir[$urandom_range(pg_rows - 1)].row_id;
            end
        endcase
    endfunction

    function automatic logic [BYTES_W-1:0] pick_rec_bytes();
        case ($urandom_range(19))
            0: return BYTES_W'($urandom);
            1: return (pg_free >= SLOT_BYTES) ? pg_free - BYTES_W'(SLOT_BYTES) : '0;
            2: return BYTES_W'(PAGE_BYTES);
            default: return BYTES_W'($urandom_range(300));
        endcase
    endfunction

    function automatic page_req_t pick_page_request(int row_cap);
        page_req_t req;
        int unsigned r;
        req.row_id    = pick_row_id();
        req.rec_bytes = pick_rec_bytes();
        r = $urandom_range(99);
        // keep directories short so searches stay cheap
        if (pg_rows > row_cap && r < 40)
            req.mode = spd_pkg::MODE_FORMAT;
        else if (r < 32) req.mode = spd_pkg::MODE_INSERT;
        else if (r < 45) req.mode = spd_pkg::MODE_LOOKUP;
        else if (r < 56) req.mode = spd_pkg::MODE_DELETE;
        else if (r < 68) req.mode = spd_pkg::MODE_EXISTS;
        else if (r < 82) req.mode = spd_pkg::MODE_SCAN;
        else if (r < 88) req.mode = spd_pkg::MODE_REWIND;
        else if (r < 93) req.mode = spd_pkg::MODE_FORMAT;
        else if (r < 96) req.mode = MODE_UNUSED;
        else begin
            // noise: any code with fully random fields
            req.mode      = MODE_W'($urandom);
            req.row_id    = ID_W'($urandom);
            req.rec_bytes = BYTES_W'($urandom);
        end
        return req;
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_page_basics();
        send_op(spd_pkg::MODE_SCAN,   '0, '0);                 // empty page, nothing to scan
        send_op(spd_pkg::MODE_LOOKUP, '0, '0);
        send_op(spd_pkg::MODE_EXISTS, '0, '0);                 // nothing handed out yet
        send_op(MODE_UNUSED, ID_MAX, BYTES_MAX);               // ignored code, all bits high
        send_op(spd_pkg::MODE_INSERT, '0, BYTES_W'(PAGE_BYTES)); // as large as the page
        send_op(spd_pkg::MODE_INSERT, '0, 15'd0);
        send_op(spd_pkg::MODE_INSERT, '0, 15'd100);
        send_op(spd_pkg::MODE_INSERT, '0, 15'd250);
        send_op(spd_pkg::MODE_LOOKUP, 31'd1, '0);
        send_op(spd_pkg::MODE_DELETE, 31'd1, '0);
        send_op(spd_pkg::MODE_DELETE, 31'd1, '0);              // already a tombstone
        send_op(spd_pkg::MODE_LOOKUP, 31'd1, '0);
        send_op(spd_pkg::MODE_EXISTS, 31'd1, '0);              // deleted, still in range
        send_op(spd_pkg::MODE_EXISTS, 31'd3, '0);              // at next id, out of range
        send_op(spd_pkg::MODE_SCAN,   '0, '0);
        send_op(spd_pkg::MODE_SCAN,   '0, '0);                 // steps over the tombstone
        send_op(spd_pkg::MODE_SCAN,   '0, '0);
        send_op(spd_pkg::MODE_SCAN,   '0, '0);                 // stays parked at the end
        send_op(spd_pkg::MODE_REWIND, '0, '0);
        send_op(spd_pkg::MODE_SCAN,   '0, '0);
        send_op(spd_pkg::MODE_INSERT, '0, pg_free - BYTES_W'(SLOT_BYTES)); // exact fill
        send_op(spd_pkg::MODE_INSERT, '0, 15'd0);
        send_op(spd_pkg::MODE_FORMAT, '0, '0);
        send_op(spd_pkg::MODE_EXISTS, '0, '0);
        drain_page();
    endtask

    task automatic test_register_extremes();
        write_page_register(spd_pkg::CFG_FIRST_ROW_ID, CFG_DATA_W'(ID_MAX - 2));
        // larger than a page
        write_page_register(spd_pkg::CFG_USABLE_BYTES, CFG_DATA_W'(BYTES_MAX));
        // registers wait for format, but exists already sees the new first id
        send_op(spd_pkg::MODE_EXISTS, 31'd0, '0);
        send_op(spd_pkg::MODE_FORMAT, '0, '0);
        send_op(spd_pkg::MODE_INSERT, '0, BYTES_MAX);
        repeat (4) send_op(spd_pkg::MODE_INSERT, '0, 15'd10);  // row ids wrap past the top
        send_op(spd_pkg::MODE_EXISTS, 31'd0, '0);              // wrapped id below first id
        send_op(spd_pkg::MODE_LOOKUP, 31'd0, '0);
        send_op(spd_pkg::MODE_EXISTS, ID_MAX - 1, '0);
        send_op(spd_pkg::MODE_DELETE, ID_MAX, '0);
        send_op(spd_pkg::MODE_SCAN,   '0, '0);
        drain_page();
        write_page_register(spd_pkg::CFG_FIRST_ROW_ID, CFG_DATA_W'(ID_MAX));
        write_page_register(spd_pkg::CFG_USABLE_BYTES, '0);
        send_op(spd_pkg::MODE_FORMAT, '0, '0);
        send_op(spd_pkg::MODE_INSERT, '0, 15'd0);              // no room even for a slot
        send_op(spd_pkg::MODE_EXISTS, ID_MAX, '0);
        drain_page();
        write_page_register(spd_pkg::CFG_FIRST_ROW_ID, '0);
        write_page_register(spd_pkg::CFG_USABLE_BYTES, CFG_DATA_W'(PAGE_BYTES));
        send_op(spd_pkg::MODE_FORMAT, '0, '0);
        drain_page();
    endtask

    task automatic choose_page_registers();
        logic [ID_W-1:0]    first_id;
        logic [BYTES_W-1:0] usable;
        case ($urandom_range(3))
            0: first_id = '0;
            1: first_id = ID_MAX - ID_W'($urandom_range(40));
            default: first_id = ID_W'($urandom);
        endcase
        case ($urandom_range(4))
            0: usable = spd_pkg::USABLE_RST;
            1: usable = BYTES_W'(PAGE_BYTES);
            2: usable = BYTES_W'($urandom);
            3: usable = BYTES_W'($urandom_range(64, 2000));
            default: usable = BYTES_MAX;
        endcase
        write_page_register(spd_pkg::CFG_FIRST_ROW_ID, CFG_DATA_W'(first_id));
        write_page_register(spd_pkg::CFG_USABLE_BYTES, CFG_DATA_W'(usable));
    endtask

    task automatic test_random_traffic(input int count, input int unsigned idle_pct,
                                       input int unsigned stall_pct);
        int row_cap;
        drain_page();
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        choose_page_registers();
        send_op(spd_pkg::MODE_FORMAT, '0, '0);
        row_cap = $urandom_range(8, 48);
        for (int i = 0; i < count; i++) begin
            if (($urandom_range(31)) == 0)
                row_cap = $urandom_range(8, 48);
            send_page_request(pick_page_request(row_cap));
        end
        drain_page();
    endtask

    // a stalled output holds one result and the next request, so the block refuses requests
    task automatic test_output_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_page_register(spd_pkg::CFG_USABLE_BYTES, CFG_DATA_W'(spd_pkg::USABLE_RST));
        send_op(spd_pkg::MODE_FORMAT, '0, '0);
        drain_page();
        recv_hold_cycles = 400;
        for (int i = 0; i < 6; i++)
            send_op(spd_pkg::MODE_INSERT, '0, BYTES_W'($urandom_range(300)));
        send_op(spd_pkg::MODE_LOOKUP, pg_first_reg + 31'd2, '0);
        send_op(spd_pkg::MODE_DELETE, pg_first_reg + 31'd3, '0);
        send_op(spd_pkg::MODE_EXISTS, pg_first_reg + 31'd3, '0);
        send_op(spd_pkg::MODE_SCAN,   '0, '0);
        drain_page();
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin
        aresetn     <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_addr    <= spd_pkg::CFG_FIRST_ROW_ID;
        cfg_wr_data <= '0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        recv_hold_cycles = 0;
        requests_sent    = 0;
        results_matched  = 0;
        result_errors    = 0;
        deepest_rows     = 0;
        pg_first_reg  = spd_pkg::FIRST_ROW_ID_RST;
        pg_usable_reg = spd_pkg::USABLE_RST;
        format_page_model();

        // synchronous reset held low, then released
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_page_basics();
        test_register_extremes();
        test_random_traffic(130, 0, 0);
        test_random_traffic(130, 54, 0);
        test_random_traffic(130, 0, 54);
        test_random_traffic(130, 17, 17);
        test_output_backpressure();

        // settle for one worst-case walk in case a stray result shows up
        repeat (DIR_SLOTS + 16) @(posedge aclk);

        $display("covered %0d page requests over four pacing phases, directory up to %0d rows",
                 requests_sent, deepest_rows);
        $display("%0d results matched, %0d field errors, %0d results outstanding",
                 results_matched, result_errors, page_results_due.size());
        if (result_errors == 0 && page_results_due.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
